[design/sdtq_pkg.sv]
package sdtq_pkg;
    localparam int DEF_QUEUE_DEPTH = 16;
    localparam int STAMP_BITS      = 60;
    localparam int ID_BITS         = 64;
    localparam int DELAY_BITS      = 32;
    localparam logic [19:0] US_PER_SECOND = 20'd1000000;

    typedef enum logic [1:0] {
        REQ_ADD    = 2'd0,
        REQ_REMOVE = 2'd1,
        REQ_TICK   = 2'd2,
        REQ_NONE   = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        RES_ADD     = 2'd0,
        RES_REMOVE  = 2'd1,
        RES_EXPIRED = 2'd2,
        RES_TICKEND = 2'd3
    } t_res;

    typedef struct packed {
        t_req                   req;
        logic                   bad;
        logic [ID_BITS-1:0]     id;
        logic [STAMP_BITS-1:0]  now;
        logic [STAMP_BITS-1:0]  delay_us;
    } t_cmd;
endpackage

[design/sdtq_front.sv]
module sdtq_front
    import sdtq_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [1:0]            i_req_type,
    input  logic [DELAY_BITS-1:0] i_delay_seconds,
    input  logic [ID_BITS-1:0]    i_task_id,
    input  logic [STAMP_BITS-1:0] i_now_us,
    output logic                  o_cmd_valid,
    input  logic                  i_cmd_ready,
    output t_cmd                  o_cmd
);
    // stage 1: register request and the multiply; stage 2: deadline add, checks
    logic                  r_v1, r_v2;
    t_req                  r_req1;
    logic [DELAY_BITS-1:0] r_dly1;
    logic [51:0]           r_prod1;
    logic [ID_BITS-1:0]    r_id1;
    logic [STAMP_BITS-1:0] r_now1;
    t_cmd                  r_cmd2;
    logic [52:0]           w_sum;
    logic                  w_adv2, w_adv1;

    assign w_adv2 = !r_v2 || i_cmd_ready;
    assign w_adv1 = !r_v1 || w_adv2;
    assign o_ready = w_adv1;
    assign o_cmd_valid = r_v2;
    assign o_cmd = r_cmd2;
    assign w_sum = {1'b0, r_prod1} + {1'b0, r_now1[51:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_adv1) r_v1 <= i_valid && (i_req_type != REQ_NONE);
            if (w_adv2) r_v2 <= r_v1;
        end
        if (w_adv1) begin
            r_req1  <= t_req'(i_req_type);
            r_dly1  <= i_delay_seconds;
            r_prod1 <= i_delay_seconds * US_PER_SECOND;
            r_id1   <= i_task_id;
            r_now1  <= i_now_us;
        end
        if (w_adv2) begin
            r_cmd2.req      <= r_req1;
            r_cmd2.id       <= r_id1;
            r_cmd2.now      <= r_now1;
            r_cmd2.delay_us <= {8'd0, r_prod1};
            r_cmd2.bad      <= (r_dly1 == '0) || (r_now1 == '0) ||
                ({1'b0, r_now1[59:52]} + {8'd0, w_sum[52]} > 9'hFF);
        end
    end
endmodule

[design/sdtq_back.sv]
module sdtq_back
    import sdtq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cmd_valid,
    output logic                  o_cmd_ready,
    input  t_cmd                  i_cmd,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [1:0]            o_result_kind,
    output logic [ID_BITS-1:0]    o_out_task_id,
    output logic                  o_ok,
    output logic                  o_rearm,
    output logic [STAMP_BITS-1:0] o_wake_delay_us,
    output logic                  o_timer_stop,
    output logic                  o_last
);
    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_TICK, S_EMIT} t_state;

    t_state                r_state;
    t_cmd                  r_cmd;
    logic [ID_BITS-1:0]    r_store [QUEUE_DEPTH];
    logic [CW-1:0]         r_count;
    logic [3:0]            r_seq;
    logic                  r_tact;
    logic [CW-1:0]         r_pos;
    logic [STAMP_BITS-1:0] w_dl;
    logic [ID_BITS-1:0]    w_head;
    logic [STAMP_BITS-1:0] w_cur;

    assign w_dl = r_cmd.now + r_cmd.delay_us;
    assign w_head = r_store[0];
    assign w_cur = r_store[r_pos[AW-1:0]][STAMP_BITS-1:0];
    assign o_cmd_ready = (r_state == S_IDLE) && (!o_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_seq   <= '0;
            r_tact  <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (o_valid && i_ready) o_valid <= 1'b0;
                    if (i_cmd_valid && o_cmd_ready) begin
                        r_cmd   <= i_cmd;
                        r_pos   <= '0;
                        if (i_cmd.req == REQ_TICK) r_state <= S_TICK;
                        else r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    // walk to insert point or matching id, one entry a cycle
                    if (r_cmd.req == REQ_ADD) begin
                        if (r_cmd.bad || r_count == CW'(QUEUE_DEPTH)) begin
                            o_valid <= 1'b1;
                            o_result_kind <= RES_ADD;
                            o_out_task_id <= '0;
                            o_ok <= 1'b0;
                            o_rearm <= 1'b0;
                            o_wake_delay_us <= '0;
                            o_timer_stop <= 1'b0;
                            o_last <= 1'b1;
                            r_state <= S_IDLE;
                        end else if (r_pos < r_count && w_cur <= w_dl) begin
                            r_pos <= r_pos + 1'b1;
                        end else begin
                            for (int i = 1; i < QUEUE_DEPTH; i++)
                                if (i <= int'(r_count) && i > int'(r_pos))
                                    r_store[i] <= r_store[i-1];
                            r_store[r_pos[AW-1:0]] <= {r_seq, w_dl};
                            r_count <= r_count + 1'b1;
                            r_seq <= r_seq + 1'b1;
                            r_tact <= 1'b1;
                            o_valid <= 1'b1;
                            o_result_kind <= RES_ADD;
                            o_out_task_id <= {r_seq, w_dl};
                            o_ok <= 1'b1;
                            o_rearm <= (r_pos == '0);
                            o_wake_delay_us <= (r_pos == '0) ? r_cmd.delay_us : '0;
                            o_timer_stop <= 1'b0;
                            o_last <= 1'b1;
                            r_state <= S_IDLE;
                        end
                    end else begin
                        if (r_pos < r_count && r_store[r_pos[AW-1:0]] != r_cmd.id) begin
                            r_pos <= r_pos + 1'b1;
                        end else begin
                            o_valid <= 1'b1;
                            o_result_kind <= RES_REMOVE;
                            o_out_task_id <= '0;
                            o_ok <= (r_pos < r_count);
                            o_rearm <= (r_pos < r_count) && r_pos == '0 &&
                                       r_count == CW'(1) && r_tact;
                            o_wake_delay_us <= '0;
                            o_timer_stop <= 1'b0;
                            o_last <= 1'b1;
                            if (r_pos < r_count) begin
                                for (int i = 0; i + 1 < QUEUE_DEPTH; i++)
                                    if (i >= int'(r_pos)) r_store[i] <= r_store[i+1];
                                r_count <= r_count - 1'b1;
                            end
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_TICK: begin
                    if (!o_valid || i_ready) begin
                        o_valid <= 1'b1;
                        o_ok <= 1'b0;
                        o_out_task_id <= '0;
                        o_rearm <= 1'b0;
                        o_wake_delay_us <= '0;
                        o_timer_stop <= 1'b0;
                        o_last <= 1'b1;
                        if (r_count == '0) begin
                            o_result_kind <= RES_TICKEND;
                            o_timer_stop <= 1'b1;
                            r_tact <= 1'b0;
                            r_state <= S_IDLE;
                        end else if (w_head[STAMP_BITS-1:0] > r_cmd.now) begin
                            o_result_kind <= RES_TICKEND;
                            o_rearm <= 1'b1;
                            o_wake_delay_us <= w_head[STAMP_BITS-1:0] - r_cmd.now;
                            r_state <= S_IDLE;
                        end else begin
                            o_result_kind <= RES_EXPIRED;
                            o_out_task_id <= w_head;
                            o_last <= 1'b0;
                            for (int i = 0; i + 1 < QUEUE_DEPTH; i++)
                                r_store[i] <= r_store[i+1];
                            r_count <= r_count - 1'b1;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

[design/sorted_delay_task_queue.sv]
// Sorted delay task queue.
// Input channel (i_valid/o_ready) takes add, remove or tick beats; req 3 is dropped.
// Output channel (o_valid/i_ready) gives one result per add or remove and
// one beat per expired task plus a closing beat per tick, o_last on the final one.
// A two-stage front end scales the delay (multiply, then add for the range check)
// and feeds a one-deep command register of the back end, which forms the deadline.
// Add and remove walk the queue with a single-entry-per-cycle scan; a tick gives
// one beat per cycle while the receiver is ready.
// The back end takes one request at a time.
// Reset empties the queue and clears the sequence counter and timer flag.
// A stalled receiver holds the back end; the front end fills and then drops ready.
module sorted_delay_task_queue
    import sdtq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [1:0]            i_req_type,
    input  logic [DELAY_BITS-1:0] i_delay_seconds,
    input  logic [ID_BITS-1:0]    i_task_id,
    input  logic [STAMP_BITS-1:0] i_now_us,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [1:0]            o_result_kind,
    output logic [ID_BITS-1:0]    o_out_task_id,
    output logic                  o_ok,
    output logic                  o_rearm,
    output logic [STAMP_BITS-1:0] o_wake_delay_us,
    output logic                  o_timer_stop,
    output logic                  o_last
);
    logic w_cmd_valid, w_cmd_ready;
    t_cmd w_cmd;

    sdtq_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_req_type, .i_delay_seconds,
        .i_task_id, .i_now_us,
        .o_cmd_valid(w_cmd_valid), .i_cmd_ready(w_cmd_ready), .o_cmd(w_cmd)
    );

    sdtq_back #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
        .i_clk, .i_rst_n,
        .i_cmd_valid(w_cmd_valid), .o_cmd_ready(w_cmd_ready), .i_cmd(w_cmd),
        .o_valid, .i_ready, .o_result_kind, .o_out_task_id, .o_ok, .o_rearm,
        .o_wake_delay_us, .o_timer_stop, .o_last
    );
endmodule

[tb/sv/sorted_delay_task_queue_tb.sv]
`timescale 1ns / 100ps

module sorted_delay_task_queue_tb;
    import sdtq_pkg::*;

    localparam int DEPTH = DEF_QUEUE_DEPTH;
    localparam logic [STAMP_BITS-1:0] STAMP_MAX = '1;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        t_res                  kind;
        logic [ID_BITS-1:0]    id;
        logic                  ok;
        logic                  rearm;
        logic [STAMP_BITS-1:0] wake;
        logic                  stop;
        logic                  last;
    } t_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_ready;
    logic [1:0]            i_req_type = REQ_NONE;
    logic [DELAY_BITS-1:0] i_delay_seconds = '0;
    logic [ID_BITS-1:0]    i_task_id = '0;
    logic [STAMP_BITS-1:0] i_now_us = '0;
    logic                  o_valid;
    logic                  i_ready = 1'b0;
    logic [1:0]            o_result_kind;
    logic [ID_BITS-1:0]    o_out_task_id;
    logic                  o_ok;
    logic                  o_rearm;
    logic [STAMP_BITS-1:0] o_wake_delay_us;
    logic                  o_timer_stop;
    logic                  o_last;

    // queue model
    logic [ID_BITS-1:0] pending_tasks[$];
    logic [3:0]         next_seq = '0;
    logic               timer_on = 1'b0;
    t_result            due_results[$];

    int  errors = 0;
    int  cycles = 0;
    int  tx_idle_pct = 0;
    int  rx_idle_pct = 0;
    int  hold_len = 0;
    logic [STAMP_BITS-1:0] clock_us = 60'd1000;

    sorted_delay_task_queue dut (.*);

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (hold_len > 0) begin
            hold_len <= hold_len - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    function automatic void push_result(t_res k, logic [ID_BITS-1:0] id, logic ok, logic rearm,
                                        logic [STAMP_BITS-1:0] wake, logic stop, logic last);
        t_result r;
        r.kind = k; r.id = id; r.ok = ok; r.rearm = rearm;
        r.wake = wake; r.stop = stop; r.last = last;
        due_results = {due_results, r};
    endfunction

    function automatic void schedule_results(t_req req, logic [DELAY_BITS-1:0] dly,
                                             logic [ID_BITS-1:0] id,
                                             logic [STAMP_BITS-1:0] now);
        logic [63:0] delay_us;
        logic [63:0] deadline;
        logic [ID_BITS-1:0] new_id;
        int pos;
        delay_us = 64'(dly) * 64'd1000000;
        deadline = 64'(now) + delay_us;
        pos = 0;
        case (req)
            REQ_ADD: begin
                if (dly == 0 || now == 0 || pending_tasks.size() >= DEPTH
                        || deadline > 64'(STAMP_MAX)) begin
                    push_result(RES_ADD, '0, 1'b0, 1'b0, '0, 1'b0, 1'b1);
                end else begin
                    while (pos < pending_tasks.size()
                            && 64'(pending_tasks[pos][STAMP_BITS-1:0]) <= deadline)
                        pos++;
                    new_id = {next_seq, deadline[STAMP_BITS-1:0]};
                    pending_tasks.insert(pos, new_id);
                    next_seq++;
                    timer_on = 1'b1;
                    if (pos == 0)
                        push_result(RES_ADD, new_id, 1'b1, 1'b1, delay_us[STAMP_BITS-1:0],
                                    1'b0, 1'b1);
                    else
                        push_result(RES_ADD, new_id, 1'b1, 1'b0, '0, 1'b0, 1'b1);
                end
            end
            REQ_REMOVE: begin
                while (pos < pending_tasks.size() && pending_tasks[pos] != id)
                    pos++;
                if (pos >= pending_tasks.size()) begin
                    push_result(RES_REMOVE, '0, 1'b0, 1'b0, '0, 1'b0, 1'b1);
                end else begin
                    pending_tasks.delete(pos);
                    push_result(RES_REMOVE, '0, 1'b1,
                                pos == 0 && pending_tasks.size() == 0 && timer_on, '0,
                                1'b0, 1'b1);
                end
            end
            REQ_TICK: begin
                while (pending_tasks.size() > 0
                        && pending_tasks[0][STAMP_BITS-1:0] <= now) begin
                    push_result(RES_EXPIRED, pending_tasks[0], 1'b0, 1'b0, '0, 1'b0, 1'b0);
                    pending_tasks.delete(0);
                end
                if (pending_tasks.size() > 0) begin
                    push_result(RES_TICKEND, '0, 1'b0, 1'b1,
                                pending_tasks[0][STAMP_BITS-1:0] - now, 1'b0, 1'b1);
                end else begin
                    timer_on = 1'b0;
                    push_result(RES_TICKEND, '0, 1'b0, 1'b0, '0, 1'b1, 1'b1);
                end
            end
            default: ;
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_result e;
        if (i_rst_n && o_valid && i_ready) begin
            if (due_results.size() == 0) begin
                $error("unexpected result beat, kind %0d", o_result_kind);
                errors++;
            end else begin
                e = due_results.pop_front();
                if (o_result_kind !== e.kind) begin
                    $error("result_kind exp %0d got %0d", e.kind, o_result_kind); errors++;
                end
                if (o_out_task_id !== e.id) begin
                    $error("out_task_id exp %h got %h", e.id, o_out_task_id); errors++;
                end
                if (o_ok !== e.ok) begin
                    $error("ok exp %0b got %0b", e.ok, o_ok); errors++;
                end
                if (o_rearm !== e.rearm) begin
                    $error("rearm exp %0b got %0b", e.rearm, o_rearm); errors++;
                end
                if (o_wake_delay_us !== e.wake) begin
                    $error("wake_delay_us exp %0d got %0d", e.wake, o_wake_delay_us); errors++;
                end
                if (o_timer_stop !== e.stop) begin
                    $error("timer_stop exp %0b got %0b", e.stop, o_timer_stop); errors++;
                end
                if (o_last !== e.last) begin
                    $error("last exp %0b got %0b", e.last, o_last); errors++;
                end
            end
        end
    end

    task automatic send_req(t_req req, logic [DELAY_BITS-1:0] dly, logic [ID_BITS-1:0] id,
                            logic [STAMP_BITS-1:0] now);
        if ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_req_type      <= req;
        i_delay_seconds <= dly;
        i_task_id       <= id;
        i_now_us        <= now;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        schedule_results(req, dly, id, now);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic test_add_rejects();
        send_req(REQ_ADD, 32'd0, '0, 60'd500);
        send_req(REQ_ADD, 32'd3, '0, 60'd0);
        send_req(REQ_ADD, 32'd1, '0, STAMP_MAX);
        send_req(REQ_ADD, 32'hFFFF_FFFF, '0, 60'hFFF_0000_0000_0000);
        send_req(REQ_NONE, 32'd7, '1, 60'd100);
        drain();
    endtask

    task automatic test_tick_remove_edges();
        send_req(REQ_TICK, '0, '0, 60'd100);
        send_req(REQ_ADD, 32'd5, '0, 60'd100);
        send_req(REQ_ADD, 32'd5, '0, 60'd100);
        send_req(REQ_ADD, 32'hFFFF_FFFF, '0, 60'd1);
        send_req(REQ_TICK, '0, '0, 60'd0);
        send_req(REQ_TICK, '0, '0, 60'd200);
        send_req(REQ_REMOVE, '0, 64'hFFFF_FFFF_FFFF_FFFF, '0);
        send_req(REQ_REMOVE, '0, pending_tasks[1], '0);
        send_req(REQ_REMOVE, '0, pending_tasks[0], '0);
        send_req(REQ_REMOVE, '0, pending_tasks[0], '0);
        send_req(REQ_TICK, '0, '0, 60'd300);
        drain();
    endtask

    task automatic test_fill_and_drain();
        repeat (DEPTH + 2) send_req(REQ_ADD, $urandom_range(1, 9), '0, 60'd1000);
        send_req(REQ_TICK, '0, '0, STAMP_MAX);
        drain();
    endtask

    task automatic test_backpressure();
        hold_len = 300;
        repeat (12) send_req(REQ_ADD, $urandom_range(1, 50), '0, clock_us);
        drain();
        send_req(REQ_TICK, '0, '0, STAMP_MAX);
        drain();
    endtask

    task automatic test_random(int n);
        int pick;
        logic [63:0] r64;
        logic [DELAY_BITS-1:0] dly;
        logic [STAMP_BITS-1:0] now;
        repeat (n) begin
            pick = $urandom_range(99);
            r64 = {$urandom(), $urandom()};
            if (pick < 40) begin
                dly = ($urandom_range(9) == 0) ? $urandom() : $urandom_range(1, 30);
                if ($urandom_range(19) == 0) dly = '0;
                now = clock_us;
                if ($urandom_range(14) == 0) now = r64[STAMP_BITS-1:0];
                if ($urandom_range(19) == 0) now = '0;
                send_req(REQ_ADD, dly, '0, now);
            end else if (pick < 65) begin
                if (pending_tasks.size() > 0 && $urandom_range(99) < 80)
                    r64 = pending_tasks[$urandom_range(pending_tasks.size() - 1)];
                send_req(REQ_REMOVE, $urandom(), r64, r64[STAMP_BITS-1:0]);
            end else begin
                clock_us += 60'($urandom_range(0, 15)) * 60'd1000000;
                now = clock_us;
                if ($urandom_range(14) == 0) now = STAMP_MAX;
                if ($urandom_range(19) == 0) now = '0;
                send_req(REQ_TICK, $urandom(), r64, now);
            end
        end
        drain();
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_add_rejects();
        test_tick_remove_edges();
        test_fill_and_drain();
        test_backpressure();
        tx_idle_pct = 37; rx_idle_pct = 50;
        test_random(20);
        tx_idle_pct = 50; rx_idle_pct = 37;
        test_random(20);
        tx_idle_pct = 0; rx_idle_pct = 0;
        test_random(20);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule

[sim.f]
design/sdtq_pkg.sv
design/sdtq_front.sv
design/sdtq_back.sv
design/sorted_delay_task_queue.sv
tb/sv/sorted_delay_task_queue_tb.sv
